// ----- hw/rtl/pas_pkg.sv -----
// shared types, constants and helpers for the pursue-and-arrive steering core
package pas_pkg;

    // square root: one register for the squares, then one register per result bit
    localparam int unsigned SQ_STEPS = 33;
    localparam int unsigned SQ_LAT   = SQ_STEPS + 1;

    // restoring divider: one register per quotient bit
    localparam int unsigned DIV_QW   = 31;

    // input register, eleven glue stages, three roots and four divides
    localparam int unsigned PIPE_LAT = 12 + 3 * SQ_LAT + 4 * DIV_QW;

    // prediction time cap of five seconds, Q16.16
    localparam logic [18:0] T_CAP = 19'd327680;

    // configuration register indexes
    localparam logic [1:0] CFG_MAX_SPEED      = 2'd0;
    localparam logic [1:0] CFG_SLOW_RADIUS    = 2'd1;
    localparam logic [1:0] CFG_ARRIVAL_RADIUS = 2'd2;
    localparam logic [1:0] CFG_MAX_ACCEL      = 2'd3;

    // configuration reset values
    localparam logic [30:0] RST_MAX_SPEED      = 31'd131072;
    localparam logic [30:0] RST_SLOW_RADIUS    = 31'd6553600;
    localparam logic [30:0] RST_ARRIVAL_RADIUS = 31'd655360;
    localparam logic [30:0] RST_MAX_ACCEL      = 31'd65536;

    // target speed selection
    localparam logic [1:0] TS_ZERO = 2'd0;
    localparam logic [1:0] TS_MAX  = 2'd1;
    localparam logic [1:0] TS_DIV  = 2'd2;

    typedef struct packed {
        logic signed [31:0] goal_x;
        logic signed [31:0] goal_y;
        logic signed [31:0] goal_vel_x;
        logic signed [31:0] goal_vel_y;
        logic signed [31:0] own_x;
        logic signed [31:0] own_y;
        logic signed [31:0] own_vel_x;
        logic signed [31:0] own_vel_y;
    } t_in;

    typedef struct packed {
        logic signed [31:0] accel_x;
        logic signed [31:0] accel_y;
        logic               was_clamped;
    } t_out;

    typedef struct packed {
        t_in  item;
        logic cap;
    } t_ctx_a;

    typedef struct packed {
        logic signed [32:0] dx;
        logic signed [32:0] dy;
        logic signed [31:0] vx;
        logic signed [31:0] vy;
    } t_ctx_b;

    typedef struct packed {
        t_ctx_b      b;
        logic [32:0] d;
        logic [1:0]  code;
    } t_ctx_c;

    typedef struct packed {
        logic               sx;
        logic               sy;
        logic               dz;
        logic signed [31:0] vx;
        logic signed [31:0] vy;
    } t_ctx_d;

    typedef struct packed {
        logic signed [32:0] fx;
        logic signed [32:0] fy;
    } t_ctx_e;

    typedef struct packed {
        logic               clamp;
        logic               sx;
        logic               sy;
        logic signed [31:0] g10x;
        logic signed [31:0] g10y;
    } t_ctx_f;

    // saturate to the signed 32-bit range
    function automatic logic signed [31:0] sat32(input logic signed [39:0] v);
        logic signed [31:0] res;
        if (v > 40'sd2147483647) begin
            res = 32'sh7fffffff;
        end else if (v < -40'sd2147483648) begin
            res = 32'sh80000000;
        end else begin
            res = v[31:0];
        end
        return res;
    endfunction

endpackage

// ----- hw/rtl/pas_isqrt.sv -----
// pipelined floor(sqrt(a*a + b*b)), one result bit per stage
module pas_isqrt import pas_pkg::*; (
    input  logic               i_clk,
    input  logic               i_en,
    input  logic signed [32:0] i_a,
    input  logic signed [32:0] i_b,
    output logic [32:0]        o_root
);

    logic [31:0] s_ma, s_mb;
    logic [63:0] s_sa, s_sb;

    logic [65:0] r_rad  [0:SQ_STEPS];
    logic [36:0] r_rem  [0:SQ_STEPS];
    logic [32:0] r_root [0:SQ_STEPS];

    logic [36:0] s_sh [0:SQ_STEPS-1];
    logic [36:0] s_tr [0:SQ_STEPS-1];
    logic        s_ge [0:SQ_STEPS-1];

    // magnitudes fit 32 bits since inputs are 32-bit values or differences of them
    assign s_ma = i_a[32] ? 32'(-i_a) : i_a[31:0];
    assign s_mb = i_b[32] ? 32'(-i_b) : i_b[31:0];
    assign s_sa = 64'(s_ma) * 64'(s_ma);
    assign s_sb = 64'(s_mb) * 64'(s_mb);

    // trial subtract for each bit position
    always_comb begin
        for (int k = 0; k < SQ_STEPS; k++) begin
            s_sh[k] = {r_rem[k][34:0], r_rad[k][65:64]};
            s_tr[k] = {2'b00, r_root[k], 2'b01};
            s_ge[k] = (s_sh[k] >= s_tr[k]);
        end
    end

    // stage registers
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rad[0]  <= 66'(s_sa) + 66'(s_sb);
            r_rem[0]  <= '0;
            r_root[0] <= '0;
            for (int k = 0; k < SQ_STEPS; k++) begin
                r_rad[k+1]  <= {r_rad[k][63:0], 2'b00};
                r_rem[k+1]  <= s_ge[k] ? (s_sh[k] - s_tr[k]) : s_sh[k];
                r_root[k+1] <= {r_root[k][31:0], s_ge[k]};
            end
        end
    end

    assign o_root = r_root[SQ_STEPS];

endmodule

// ----- hw/rtl/pas_div.sv -----
// pipelined restoring divider, quotient known to fit 31 bits
module pas_div import pas_pkg::*; (
    input  logic              i_clk,
    input  logic              i_en,
    input  logic [63:0]       i_num,
    input  logic [32:0]       i_den,
    output logic [DIV_QW-1:0] o_quo
);

    logic [63:0]       r_rem [0:DIV_QW-1];
    logic [32:0]       r_den [0:DIV_QW-1];
    logic [DIV_QW-1:0] r_quo [0:DIV_QW-1];

    logic [63:0]       s_rem [0:DIV_QW-1];
    logic [32:0]       s_den [0:DIV_QW-1];
    logic [DIV_QW-1:0] s_quo [0:DIV_QW-1];
    logic [63:0]       s_dsh [0:DIV_QW-1];
    logic              s_ge  [0:DIV_QW-1];

    // stage sources and compare against the shifted divisor
    always_comb begin
        s_rem[0] = i_num;
        s_den[0] = i_den;
        s_quo[0] = '0;
        for (int k = 1; k < DIV_QW; k++) begin
            s_rem[k] = r_rem[k-1];
            s_den[k] = r_den[k-1];
            s_quo[k] = r_quo[k-1];
        end
        for (int k = 0; k < DIV_QW; k++) begin
            s_dsh[k] = 64'(s_den[k]) << (DIV_QW - 1 - k);
            s_ge[k]  = (s_rem[k] >= s_dsh[k]);
        end
    end

    // stage registers
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < DIV_QW; k++) begin
                r_rem[k] <= s_ge[k] ? (s_rem[k] - s_dsh[k]) : s_rem[k];
                r_den[k] <= s_den[k];
                r_quo[k] <= {s_quo[k][DIV_QW-2:0], s_ge[k]};
            end
        end
    end

    assign o_quo = r_quo[DIV_QW-1];

endmodule

// ----- hw/rtl/pursue_arrive_steering_core.sv -----
// top level of the pursue-and-arrive steering core
//
// Input channel i_valid/o_ready carries one agent/target pair (t_in); output
// channel o_valid/i_ready returns the steering acceleration (t_out).
// The core is a single pipeline that takes one item every cycle while
// o_ready is high. Its depth PIPE_LAT is set by three 34-stage square
// roots in series (distance and speed side by side, direction, length) and
// four 31-stage restoring dividers (prediction time, target speed, desired
// velocity, clamp scaling) plus twelve single-register stages, input and
// output registers included.
// All stages advance together; when the output holds a result that the
// receiver does not take, the whole pipeline holds and o_ready drops.
// Bubbles travel as cleared valid bits, nothing is dropped or repeated.
// Synchronous active-low reset clears all valid bits and loads the four
// configuration registers with their defaults. The user must write them
// via i_cfg_we/i_cfg_idx/i_cfg_data only while idle; the core does not check.
module pursue_arrive_steering_core import pas_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  t_in         i_in,
    output logic        o_valid,
    input  logic        i_ready,
    output t_out        o_out,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [30:0] i_cfg_data
);

    logic s_en;

    logic [30:0] r_max_speed, r_slow_radius, r_arrival_radius, r_max_accel;
    logic [PIPE_LAT-1:0] r_vld;

    // global advance: move whenever the output slot is empty or taken
    assign s_en    = !r_vld[PIPE_LAT-1] || i_ready;
    assign o_ready = s_en;
    assign o_valid = r_vld[PIPE_LAT-1];

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_speed      <= RST_MAX_SPEED;
            r_slow_radius    <= RST_SLOW_RADIUS;
            r_arrival_radius <= RST_ARRIVAL_RADIUS;
            r_max_accel      <= RST_MAX_ACCEL;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_MAX_SPEED:      r_max_speed      <= i_cfg_data;
                CFG_SLOW_RADIUS:    r_slow_radius    <= i_cfg_data;
                CFG_ARRIVAL_RADIUS: r_arrival_radius <= i_cfg_data;
                CFG_MAX_ACCEL:      r_max_accel      <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // valid bits travel with the data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (s_en) begin
            r_vld <= {r_vld[PIPE_LAT-2:0], i_valid};
        end
    end

    // ---------------- input stage: position differences
    t_in                r_in;
    logic signed [32:0] r_ddx, r_ddy;
    logic signed [32:0] s_vx33, s_vy33;

    always_ff @(posedge i_clk) begin
        if (s_en) begin
            r_in  <= i_in;
            r_ddx <= 33'(i_in.goal_x) - 33'(i_in.own_x);
            r_ddy <= 33'(i_in.goal_y) - 33'(i_in.own_y);
        end
    end

    assign s_vx33 = 33'(r_in.own_vel_x);
    assign s_vy33 = 33'(r_in.own_vel_y);

    // ---------------- distance and speed
    logic [32:0] s_dist, s_spd;

    pas_isqrt u_sq_dist (
        .i_clk (i_clk), .i_en (s_en), .i_a (r_ddx), .i_b (r_ddy), .o_root (s_dist)
    );

    pas_isqrt u_sq_spd (
        .i_clk (i_clk), .i_en (s_en), .i_a (s_vx33), .i_b (s_vy33), .o_root (s_spd)
    );

    t_in r_ca [0:SQ_LAT-1];

    always_ff @(posedge i_clk) begin
        if (s_en) begin
            r_ca[0] <= r_in;
            for (int k = 1; k < SQ_LAT; k++) begin
                r_ca[k] <= r_ca[k-1];
            end
        end
    end

    // ---------------- prediction time cap and divide setup
    logic [35:0] s_spd5;
    t_ctx_a      r_c2;
    logic [63:0] r_tnum;
    logic [32:0] r_tden;

    assign s_spd5 = 36'(s_spd) * 36'd5;

    always_ff @(posedge i_clk) begin
        if (s_en) begin
            r_c2.item <= r_ca[SQ_LAT-1];
            r_c2.cap  <= (s_spd5 <= 36'(s_dist));
            r_tnum    <= {15'd0, s_dist, 16'd0};
            r_tden    <= s_spd;
        end
    end

    logic [DIV_QW-1:0] s_tq;

    pas_div u_div_t (
        .i_clk (i_clk), .i_en (s_en), .i_num (r_tnum), .i_den (r_tden), .o_quo (s_tq)
    );

    t_ctx_a r_cb [0:DIV_QW-1];

    always_ff @(posedge i_clk) begin
        if (s_en) begin
            r_cb[0] <= r_c2;
            for (int k = 1; k < DIV_QW; k++) begin
                r_cb[k] <= r_cb[k-1];
            end
        end
    end

    // ---------------- prediction time select
    logic [18:0] r_t;
    t_in         r_i3;

    always_ff @(posedge i_clk) begin
        if (s_en) begin
            r_t  <= r_cb[DIV_QW-1].cap ? T_CAP : s_tq[18:0];
            r_i3 <= r_cb[DIV_QW-1].item;
        end
    end

    // ---------------- target velocity times prediction time
    logic signed [51:0] s_gvx52, s_gvy52, s_t52;
    logic signed [51:0] r_mx, r_my;
    t_in                r_i4;

    assign s_gvx52 = 52'(r_i3.goal_vel_x);
    assign s_gvy52 = 52'(r_i3.goal_vel_y);
    assign s_t52   = {33'd0, r_t};

    always_ff @(posedge i_clk) begin
        if (s_en) begin
            r_mx <= s_gvx52 * s_t52;
            r_my <= s_gvy52 * s_t52;
            r_i4 <= r_i3;
        end
    end

    // ---------------- predicted point, saturated
    logic signed [39:0] s_gx40, s_gy40, s_mx40, s_my40;
    logic signed [31:0] r_px, r_py;
    t_in                r_i5;

    assign s_gx40 = 40'(r_i4.goal_x);
    assign s_gy40 = 40'(r_i4.goal_y);
    assign s_mx40 = 40'(r_mx >>> 16);
    assign s_my40 = 40'(r_my >>> 16);

    always_ff @(posedge i_clk) begin
        if (s_en) begin
            r_px <= sat32(s_gx40 + s_mx40);
            r_py <= sat32(s_gy40 + s_my40);
            r_i5 <= r_i4;
        end
    end

    // ---------------- direction to predicted point
    logic signed [32:0] r_dx, r_dy;
    t_ctx_b             r_c6;

    always_ff @(posedge i_clk) begin
        if (s_en) begin
            r_dx    <= 33'(r_px) - 33'(r_i5.own_x);
            r_dy    <= 33'(r_py) - 33'(r_i5.own_y);
            r_c6.dx <= 33'(r_px) - 33'(r_i5.own_x);
            r_c6.dy <= 33'(r_py) - 33'(r_i5.own_y);
            r_c6.vx <= r_i5.own_vel_x;
            r_c6.vy <= r_i5.own_vel_y;
        end
    end

    logic [32:0] s_d;

    pas_isqrt u_sq_dir (
        .i_clk (i_clk), .i_en (s_en), .i_a (r_dx), .i_b (r_dy), .o_root (s_d)
    );

    t_ctx_b r_cc [0:SQ_LAT-1];

    always_ff @(posedge i_clk) begin
        if (s_en) begin
            r_cc[0] <= r_c6;
            for (int k = 1; k < SQ_LAT; k++) begin
                r_cc[k] <= r_cc[k-1];
            end
        end
    end

    // ---------------- arrive branch and speed product
    logic [1:0]  s_code;
    t_ctx_c      r_c7;
    logic [63:0] r_tsnum;

    always_comb begin
        if (s_d < 33'(r_arrival_radius)) begin
            s_code = TS_ZERO;
        end else if (s_d > 33'(r_slow_radius)) begin
            s_code = TS_MAX;
        end else if (r_slow_radius == '0) begin
            s_code = TS_ZERO;
        end else begin
            s_code = TS_DIV;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_en) begin
            r_c7.b    <= r_cc[SQ_LAT-1];
            r_c7.d    <= s_d;
            r_c7.code <= s_code;
            r_tsnum   <= 64'(r_max_speed) * 64'(s_d);
        end
    end

    logic [DIV_QW-1:0] s_tsq;

    pas_div u_div_ts (
        .i_clk (i_clk), .i_en (s_en), .i_num (r_tsnum), .i_den ({2'b00, r_slow_radius}),
        .o_quo (s_tsq)
    );

    t_ctx_c r_cd [0:DIV_QW-1];

    always_ff @(posedge i_clk) begin
        if (s_en) begin
            r_cd[0] <= r_c7;
            for (int k = 1; k < DIV_QW; k++) begin
                r_cd[k] <= r_cd[k-1];
            end
        end
    end

    // ---------------- target speed select
    logic [30:0] s_ts, r_ts;
    t_ctx_c      r_c8;

    always_comb begin
        case (r_cd[DIV_QW-1].code)
            TS_ZERO: s_ts = '0;
            TS_MAX:  s_ts = r_max_speed;
            TS_DIV:  s_ts = s_tsq;
            default: s_ts = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (s_en) begin
            r_ts <= s_ts;
            r_c8 <= r_cd[DIV_QW-1];
        end
    end

    // ---------------- direction magnitude times target speed
    logic [31:0] s_adx, s_ady;
    logic [63:0] r_nx, r_ny;
    logic [32:0] r_d9;
    t_ctx_d      r_c9;

    assign s_adx = r_c8.b.dx[32] ? 32'(-r_c8.b.dx) : r_c8.b.dx[31:0];
    assign s_ady = r_c8.b.dy[32] ? 32'(-r_c8.b.dy) : r_c8.b.dy[31:0];

    always_ff @(posedge i_clk) begin
        if (s_en) begin
            r_nx    <= 64'(s_adx) * 64'(r_ts);
            r_ny    <= 64'(s_ady) * 64'(r_ts);
            r_d9    <= r_c8.d;
            r_c9.sx <= r_c8.b.dx[32];
            r_c9.sy <= r_c8.b.dy[32];
            r_c9.dz <= (r_c8.d == '0);
            r_c9.vx <= r_c8.b.vx;
            r_c9.vy <= r_c8.b.vy;
        end
    end

    logic [DIV_QW-1:0] s_desqx, s_desqy;

    pas_div u_div_desx (
        .i_clk (i_clk), .i_en (s_en), .i_num (r_nx), .i_den (r_d9), .o_quo (s_desqx)
    );

    pas_div u_div_desy (
        .i_clk (i_clk), .i_en (s_en), .i_num (r_ny), .i_den (r_d9), .o_quo (s_desqy)
    );

    t_ctx_d r_ce [0:DIV_QW-1];

    always_ff @(posedge i_clk) begin
        if (s_en) begin
            r_ce[0] <= r_c9;
            for (int k = 1; k < DIV_QW; k++) begin
                r_ce[k] <= r_ce[k-1];
            end
        end
    end

    // ---------------- desired velocity minus own velocity
    logic signed [32:0] s_desx, s_desy;
    logic signed [32:0] r_fx, r_fy;
    t_ctx_e             r_c10;
    t_ctx_d             s_cl;

    assign s_cl = r_ce[DIV_QW-1];

    always_comb begin
        if (s_cl.dz) begin
            s_desx = '0;
            s_desy = '0;
        end else begin
            s_desx = s_cl.sx ? -{2'b00, s_desqx} : {2'b00, s_desqx};
            s_desy = s_cl.sy ? -{2'b00, s_desqy} : {2'b00, s_desqy};
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_en) begin
            r_fx     <= s_desx - 33'(s_cl.vx);
            r_fy     <= s_desy - 33'(s_cl.vy);
            r_c10.fx <= s_desx - 33'(s_cl.vx);
            r_c10.fy <= s_desy - 33'(s_cl.vy);
        end
    end

    logic [32:0] s_l;

    pas_isqrt u_sq_len (
        .i_clk (i_clk), .i_en (s_en), .i_a (r_fx), .i_b (r_fy), .o_root (s_l)
    );

    t_ctx_e r_cf [0:SQ_LAT-1];

    always_ff @(posedge i_clk) begin
        if (s_en) begin
            r_cf[0] <= r_c10;
            for (int k = 1; k < SQ_LAT; k++) begin
                r_cf[k] <= r_cf[k-1];
            end
        end
    end

    // ---------------- clamp decision, gain path and clamp products
    t_ctx_e             s_fl;
    logic [31:0]        s_afx, s_afy;
    logic signed [39:0] s_fx40, s_fy40;
    logic [36:0]        s_l10;
    logic [63:0]        r_ox, r_oy;
    logic [32:0]        r_l;
    t_ctx_f             r_c11;

    assign s_fl   = r_cf[SQ_LAT-1];
    assign s_afx  = s_fl.fx[32] ? 32'(-s_fl.fx) : s_fl.fx[31:0];
    assign s_afy  = s_fl.fy[32] ? 32'(-s_fl.fy) : s_fl.fy[31:0];
    assign s_fx40 = 40'(s_fl.fx);
    assign s_fy40 = 40'(s_fl.fy);
    assign s_l10  = 37'(s_l) * 37'd10;

    always_ff @(posedge i_clk) begin
        if (s_en) begin
            r_ox        <= 64'(s_afx) * 64'(r_max_accel);
            r_oy        <= 64'(s_afy) * 64'(r_max_accel);
            r_l         <= s_l;
            r_c11.clamp <= (s_l10 > 37'(r_max_accel));
            r_c11.sx    <= s_fl.fx[32];
            r_c11.sy    <= s_fl.fy[32];
            r_c11.g10x  <= sat32(s_fx40 * 40'sd10);
            r_c11.g10y  <= sat32(s_fy40 * 40'sd10);
        end
    end

    logic [DIV_QW-1:0] s_oqx, s_oqy;

    pas_div u_div_outx (
        .i_clk (i_clk), .i_en (s_en), .i_num (r_ox), .i_den (r_l), .o_quo (s_oqx)
    );

    pas_div u_div_outy (
        .i_clk (i_clk), .i_en (s_en), .i_num (r_oy), .i_den (r_l), .o_quo (s_oqy)
    );

    t_ctx_f r_cg [0:DIV_QW-1];

    always_ff @(posedge i_clk) begin
        if (s_en) begin
            r_cg[0] <= r_c11;
            for (int k = 1; k < DIV_QW; k++) begin
                r_cg[k] <= r_cg[k-1];
            end
        end
    end

    // ---------------- output register
    t_ctx_f s_gl;
    t_out   r_out;

    assign s_gl = r_cg[DIV_QW-1];

    always_ff @(posedge i_clk) begin
        if (s_en) begin
            if (s_gl.clamp) begin
                r_out.accel_x <= s_gl.sx ? -{1'b0, s_oqx} : {1'b0, s_oqx};
                r_out.accel_y <= s_gl.sy ? -{1'b0, s_oqy} : {1'b0, s_oqy};
            end else begin
                r_out.accel_x <= s_gl.g10x;
                r_out.accel_y <= s_gl.g10y;
            end
            r_out.was_clamped <= s_gl.clamp;
        end
    end

    assign o_out = r_out;

endmodule

// ----- hw/rtl/pas_chk.sv -----
// port-level checker for the steering core, bound to the top level
module pas_chk import pas_pkg::*; (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_valid,
    input logic o_ready,
    input logic o_valid,
    input logic i_ready,
    input t_out o_out
);

    // a result is held until transferred
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid)
        else $error("output valid dropped before transfer");

    // a stalled result keeps its value
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> $stable(o_out))
        else $error("output changed while stalled");

    // reset empties the pipeline
    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid right after reset");

    // the pipeline only holds back when a result waits
    a_ready_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> o_ready)
        else $error("input stalled with empty output");

    // a clamped result is bounded by a 31-bit limit
    a_clamp_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_out.was_clamped |->
            (o_out.accel_x != 32'sh80000000) && (o_out.accel_y != 32'sh80000000))
        else $error("clamped output out of range");

endmodule

bind pursue_arrive_steering_core pas_chk u_pas_chk (.*);
